// ===== hw/rtl/rmg_pkg.sv =====
`timescale 1ns / 1ps
package rmg_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int VALUE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int SAT_BITS = (VALUE_BITS > 16) ? 16 : VALUE_BITS;
    localparam int PW = 32;   // phase width
    localparam int CW = 34;   // cordic datapath width
    localparam int TW = 18;   // trig value width
    localparam int AW = 56;   // accumulation width

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [PW-1:0] PHASE_KEEP = {{ANGLE_BITS{1'b1}}, {(PW-ANGLE_BITS){1'b0}}};
    localparam logic [PW-1:0] QUARTER = 32'h4000_0000;
    localparam logic [PW-1:0] HALF    = 32'h8000_0000;
    localparam logic signed [AW-1:0] ONE_Q14 = 56'sd16384;
    localparam logic signed [AW-1:0] ONE_Q28 = 56'sd268435456;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef enum logic [2:0] {
        F_EULER = 3'd0,
        F_QUAT  = 3'd1,
        F_AXIS  = 3'd2,
        F_ROT_X = 3'd3,
        F_ROT_Y = 3'd4,
        F_ROT_Z = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]         func;
        logic [15:0]        angle_a;
        logic [15:0]        angle_b;
        logic [15:0]        angle_c;
        logic signed [15:0] vec_w;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } t_req;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_res;

    // classified word passed from front to back
    typedef struct packed {
        logic [2:0]           func;
        logic signed [CW-1:0] za;
        logic signed [CW-1:0] zb;
        logic signed [CW-1:0] zc;
        logic                 na;
        logic                 nb;
        logic                 nc;
        logic signed [15:0]   vec_w;
        logic signed [15:0]   vec_x;
        logic signed [15:0]   vec_y;
        logic signed [15:0]   vec_z;
    } t_task;

    function automatic logic signed [AW-1:0] rnd_shift(input logic signed [AW-1:0] v,
                                                       input int s);
        rnd_shift = (v + (56'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = (56'sd1 <<< (SAT_BITS - 1)) - 56'sd1;
        lo = -hi - 56'sd1;
        if (v > hi)
            sat = hi[15:0];
        else if (v < lo)
            sat = lo[15:0];
        else
            sat = v[15:0];
    endfunction

endpackage

// ===== hw/rtl/rmg_front.sv =====
`timescale 1ns / 1ps
module rmg_front import rmg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_req  i_req,
    output logic  busy,
    input  logic  i_full,
    output logic  o_push,
    output t_task o_task
);

    logic  r_valid;
    t_task r_task;
    t_task n_task;
    logic [PW-1:0] pa, pb, pc;

    function automatic logic [PW-1:0] to_phase(input logic [15:0] a);
        to_phase = {a, 16'd0} & PHASE_KEEP;
    endfunction

    // fold into [-1/4, 1/4) turn; flag says negate the result
    function automatic logic [CW:0] fold(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        logic          n;
        q = p + QUARTER;
        n = q[PW-1];
        q = n ? (p - HALF) : p;
        fold = {n, {(CW-PW){q[PW-1]}}, q};
    endfunction

    always_comb begin
        pa = to_phase(i_req.angle_a);
        if (t_func'(i_req.func) == F_AXIS) begin
            pa = pa >> 1;
        end
        pb = to_phase(i_req.angle_b);
        pc = to_phase(i_req.angle_c);
        n_task.func  = i_req.func;
        {n_task.na, n_task.za} = fold(pa);
        {n_task.nb, n_task.zb} = fold(pb);
        {n_task.nc, n_task.zc} = fold(pc);
        n_task.vec_w = i_req.vec_w;
        n_task.vec_x = i_req.vec_x;
        n_task.vec_y = i_req.vec_y;
        n_task.vec_z = i_req.vec_z;
    end

    assign busy   = r_valid && i_full;
    assign o_push = r_valid && !i_full;
    assign o_task = r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!busy) begin
            r_valid <= start;
        end
        if (!busy) begin
            r_task <= n_task;
        end
    end

endmodule

// ===== hw/rtl/rmg_queue.sv =====
`timescale 1ns / 1ps
module rmg_queue import rmg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    output logic  o_valid,
    output t_task o_task
);

    t_task      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    // back end never stalls, so anything present leaves this cycle
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid;
    assign o_full  = (r_cnt == 2'd2);
    assign o_task  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop)    r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

endmodule

// ===== hw/rtl/rmg_cordic.sv =====
`timescale 1ns / 1ps
module rmg_cordic import rmg_pkg::*; (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_z,
    input  logic                 i_neg,
    output logic signed [TW-1:0] o_cos,
    output logic signed [TW-1:0] o_sin
);

    logic signed [CW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_z [CORDIC_STEPS+1];
    logic                 r_neg [CORDIC_STEPS+1];
    logic signed [CW-1:0] xr, yr;

    always_ff @(posedge i_clk) begin
        r_x[0]   <= CORDIC_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= i_z;
        r_neg[0] <= i_neg;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam int K = i % 32;
        localparam logic signed [CW-1:0] ANG = {{(CW-32){1'b0}}, ATAN_TURNS[K]};
        always_ff @(posedge i_clk) begin
            if (r_z[i][CW-1]) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> K);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> K);
                r_z[i+1] <= r_z[i] + ANG;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> K);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> K);
                r_z[i+1] <= r_z[i] - ANG;
            end
            r_neg[i+1] <= r_neg[i];
        end
    end

    assign xr = (r_x[CORDIC_STEPS] + 34'sd32768) >>> 16;
    assign yr = (r_y[CORDIC_STEPS] + 34'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        o_cos <= r_neg[CORDIC_STEPS] ? -xr[TW-1:0] : xr[TW-1:0];
        o_sin <= r_neg[CORDIC_STEPS] ? -yr[TW-1:0] : yr[TW-1:0];
    end

endmodule

// ===== hw/rtl/rmg_back.sv =====
`timescale 1ns / 1ps
module rmg_back import rmg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_task i_task,
    output logic  o_valid,
    output t_res  o_res
);

    localparam int SL = CORDIC_STEPS + 2;

    logic  r_sv [SL];
    t_task r_sd [SL];
    logic signed [TW-1:0] sa, ca, sb, cb, sc, cc;

    rmg_cordic u_lane_a (.i_clk(i_clk), .i_z(i_task.za), .i_neg(i_task.na),
                         .o_cos(ca), .o_sin(sa));
    rmg_cordic u_lane_b (.i_clk(i_clk), .i_z(i_task.zb), .i_neg(i_task.nb),
                         .o_cos(cb), .o_sin(sb));
    rmg_cordic u_lane_c (.i_clk(i_clk), .i_z(i_task.zc), .i_neg(i_task.nc),
                         .o_cos(cc), .o_sin(sc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SL; j++) r_sv[j] <= 1'b0;
        end else begin
            r_sv[0] <= i_valid;
            for (int j = 1; j < SL; j++) r_sv[j] <= r_sv[j-1];
        end
        r_sd[0] <= i_task;
        for (int j = 1; j < SL; j++) r_sd[j] <= r_sd[j-1];
    end

    // stage 1: pair products, sin * axis
    logic                 r1_v;
    logic [2:0]           r1_func;
    logic signed [15:0]   r1_vw, r1_vx, r1_vy, r1_vz;
    logic signed [TW-1:0] r1_sa, r1_ca, r1_cb, r1_sc, r1_cc;
    logic signed [31:0]   r1_cacc, r1_sacb, r1_casc, r1_sacc, r1_cacb;
    logic signed [31:0]   r1_sasc, r1_sasb, r1_casb, r1_sbsc, r1_sbcc;
    logic signed [33:0]   r1_ax, r1_ay, r1_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= r_sv[SL-1];
        r1_func <= r_sd[SL-1].func;
        r1_vw   <= r_sd[SL-1].vec_w;
        r1_vx   <= r_sd[SL-1].vec_x;
        r1_vy   <= r_sd[SL-1].vec_y;
        r1_vz   <= r_sd[SL-1].vec_z;
        r1_sa <= sa; r1_ca <= ca; r1_cb <= cb; r1_sc <= sc; r1_cc <= cc;
        r1_cacc <= 32'(ca * cc);
        r1_sacb <= 32'(sa * cb);
        r1_casc <= 32'(ca * sc);
        r1_sacc <= 32'(sa * cc);
        r1_cacb <= 32'(ca * cb);
        r1_sasc <= 32'(sa * sc);
        r1_sasb <= 32'(sa * sb);
        r1_casb <= 32'(ca * sb);
        r1_sbsc <= 32'(sb * sc);
        r1_sbcc <= 32'(sb * cc);
        r1_ax   <= 34'(sa * r_sd[SL-1].vec_x);
        r1_ay   <= 34'(sa * r_sd[SL-1].vec_y);
        r1_az   <= 34'(sa * r_sd[SL-1].vec_z);
    end

    // stage 2: triple products, quaternion parts
    logic                 r2_v;
    logic [2:0]           r2_func;
    logic signed [TW-1:0] r2_sa, r2_ca, r2_cb;
    logic signed [31:0]   r2_cacc, r2_casc, r2_sacc, r2_sasc;
    logic signed [31:0]   r2_sasb, r2_casb, r2_sbsc, r2_sbcc;
    logic signed [49:0]   r2_sacbsc, r2_sacbcc, r2_cacbsc, r2_cacbcc;
    logic signed [17:0]   r2_qw, r2_qx, r2_qy, r2_qz;
    logic                 axis1;

    assign axis1 = (t_func'(r1_func) == F_AXIS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_func <= r1_func;
        r2_sa <= r1_sa; r2_ca <= r1_ca; r2_cb <= r1_cb;
        r2_cacc <= r1_cacc; r2_casc <= r1_casc; r2_sacc <= r1_sacc;
        r2_sasc <= r1_sasc; r2_sasb <= r1_sasb; r2_casb <= r1_casb;
        r2_sbsc <= r1_sbsc; r2_sbcc <= r1_sbcc;
        r2_sacbsc <= 50'(r1_sacb * r1_sc);
        r2_sacbcc <= 50'(r1_sacb * r1_cc);
        r2_cacbsc <= 50'(r1_cacb * r1_sc);
        r2_cacbcc <= 50'(r1_cacb * r1_cc);
        r2_qw <= axis1 ? r1_ca : 18'(r1_vw);
        r2_qx <= axis1 ? 18'(rnd_shift(AW'(r1_ax), 14)) : 18'(r1_vx);
        r2_qy <= axis1 ? 18'(rnd_shift(AW'(r1_ay), 14)) : 18'(r1_vy);
        r2_qz <= axis1 ? 18'(rnd_shift(AW'(r1_az), 14)) : 18'(r1_vz);
    end

    // stage 3: quaternion products
    logic                 r3_v;
    logic [2:0]           r3_func;
    logic signed [TW-1:0] r3_sa, r3_ca, r3_cb;
    logic signed [31:0]   r3_cacc, r3_casc, r3_sacc, r3_sasc;
    logic signed [31:0]   r3_sasb, r3_casb, r3_sbsc, r3_sbcc;
    logic signed [49:0]   r3_sacbsc, r3_sacbcc, r3_cacbsc, r3_cacbcc;
    logic signed [35:0]   r3_xx, r3_yy, r3_zz, r3_xy, r3_xz, r3_yz, r3_wx, r3_wy, r3_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_func <= r2_func;
        r3_sa <= r2_sa; r3_ca <= r2_ca; r3_cb <= r2_cb;
        r3_cacc <= r2_cacc; r3_casc <= r2_casc; r3_sacc <= r2_sacc;
        r3_sasc <= r2_sasc; r3_sasb <= r2_sasb; r3_casb <= r2_casb;
        r3_sbsc <= r2_sbsc; r3_sbcc <= r2_sbcc;
        r3_sacbsc <= r2_sacbsc; r3_sacbcc <= r2_sacbcc;
        r3_cacbsc <= r2_cacbsc; r3_cacbcc <= r2_cacbcc;
        r3_xx <= r2_qx * r2_qx; r3_yy <= r2_qy * r2_qy; r3_zz <= r2_qz * r2_qz;
        r3_xy <= r2_qx * r2_qy; r3_xz <= r2_qx * r2_qz; r3_yz <= r2_qy * r2_qz;
        r3_wx <= r2_qw * r2_qx; r3_wy <= r2_qw * r2_qy; r3_wz <= r2_qw * r2_qz;
    end

    // stage 4: sums, rounding, mode select, saturation
    logic signed [AW-1:0] m [9];
    logic signed [AW-1:0] c4, s4;

    always_comb begin
        c4 = AW'(r3_ca);
        s4 = AW'(r3_sa);
        for (int j = 0; j < 9; j++) m[j] = '0;
        case (t_func'(r3_func))
            F_EULER: begin
                m[0] = rnd_shift((AW'(r3_cacc) <<< 14) - AW'(r3_sacbsc), 28);
                m[1] = rnd_shift(-(AW'(r3_casc) <<< 14) - AW'(r3_sacbcc), 28);
                m[2] = rnd_shift(AW'(r3_sasb), 14);
                m[3] = rnd_shift((AW'(r3_sacc) <<< 14) + AW'(r3_cacbsc), 28);
                m[4] = rnd_shift(-(AW'(r3_sasc) <<< 14) + AW'(r3_cacbcc), 28);
                m[5] = rnd_shift(-AW'(r3_casb), 14);
                m[6] = rnd_shift(AW'(r3_sbsc), 14);
                m[7] = rnd_shift(AW'(r3_sbcc), 14);
                m[8] = AW'(r3_cb);
            end
            F_QUAT, F_AXIS: begin
                m[0] = rnd_shift(ONE_Q28 - 2 * (AW'(r3_yy) + AW'(r3_zz)), 14);
                m[1] = rnd_shift(2 * (AW'(r3_xy) - AW'(r3_wz)), 14);
                m[2] = rnd_shift(2 * (AW'(r3_xz) + AW'(r3_wy)), 14);
                m[3] = rnd_shift(2 * (AW'(r3_xy) + AW'(r3_wz)), 14);
                m[4] = rnd_shift(ONE_Q28 - 2 * (AW'(r3_xx) + AW'(r3_zz)), 14);
                m[5] = rnd_shift(2 * (AW'(r3_yz) - AW'(r3_wx)), 14);
                m[6] = rnd_shift(2 * (AW'(r3_xz) - AW'(r3_wy)), 14);
                m[7] = rnd_shift(2 * (AW'(r3_yz) + AW'(r3_wx)), 14);
                m[8] = rnd_shift(ONE_Q28 - 2 * (AW'(r3_xx) + AW'(r3_yy)), 14);
            end
            F_ROT_X: begin
                m[0] = ONE_Q14; m[4] = c4; m[5] = -s4; m[7] = s4; m[8] = c4;
            end
            F_ROT_Y: begin
                m[0] = c4; m[2] = s4; m[4] = ONE_Q14; m[6] = -s4; m[8] = c4;
            end
            F_ROT_Z: begin
                m[0] = c4; m[1] = -s4; m[3] = s4; m[4] = c4; m[8] = ONE_Q14;
            end
            default: begin
                m[0] = ONE_Q14; m[4] = ONE_Q14; m[8] = ONE_Q14;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r3_v;
        o_res.m00 <= sat(m[0]);
        o_res.m01 <= sat(m[1]);
        o_res.m02 <= sat(m[2]);
        o_res.m10 <= sat(m[3]);
        o_res.m11 <= sat(m[4]);
        o_res.m12 <= sat(m[5]);
        o_res.m20 <= sat(m[6]);
        o_res.m21 <= sat(m[7]);
        o_res.m22 <= sat(m[8]);
    end

endmodule

// ===== hw/rtl/rotation_matrix_generator_unit.sv =====
`timescale 1ns / 1ps
// Path: start is registered in the front, passes the queue, the three CORDIC lanes and the back-end stages to o_valid.
// Throughput: one word per cycle while busy is low; the three CORDIC lanes are fully pipelined.
// busy rises only if the front-to-back queue fills; the back end never stalls.
// Reset: synchronous, active low; clears all valid flags, no words in flight.
module rotation_matrix_generator_unit import rmg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    logic  push, full, q_valid;
    t_task f_task, q_task;

    rmg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .i_full(full), .o_push(push), .o_task(f_task)
    );

    rmg_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_task(f_task),
        .o_full(full), .o_valid(q_valid), .o_task(q_task)
    );

    rmg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_task(q_task),
        .o_valid(o_valid), .o_res(o_res)
    );

endmodule

// ===== tb/tb_rotation_matrix_generator_unit.sv =====
`timescale 1ns / 1ps
module tb_rotation_matrix_generator_unit;
    import rmg_pkg::*;

    localparam int LATENCY   = CORDIC_STEPS + 7;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_valid;
    t_res o_res;

    int send_idle_pct = 0;
    int n_sent = 0;
    int n_matrices = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    int func_seen [8];
    t_res matrix_q [$];

    always #4 i_clk = ~i_clk;

    rotation_matrix_generator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // ---- predictor ----
    function automatic longint asr_l(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_l(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] angle_phase(logic [15:0] a);
        return {a, 16'h0} & PHASE_KEEP;
    endfunction

    task automatic cordic_trig(input logic [31:0] p, output longint s, output longint c);
        logic neg;
        longint x, y, z, dx, dy;
        neg = ((p + QUARTER) & HALF) != 0;
        x = 652032874;
        y = 0;
        if (neg) p = p - HALF;
        z = longint'(signed'(p));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = asr_l(y, i % 32);
            dy = asr_l(x, i % 32);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i % 32]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i % 32]);
            end
        end
        c = rnd_l(x, 16);
        s = rnd_l(y, 16);
        if (neg) begin
            c = -c; s = -s;
        end
    endtask

    function automatic logic signed [15:0] clamp_q14(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (SAT_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[15:0];
    endfunction

    task automatic quat_matrix(input longint w, x, y, z, output longint m [9]);
        longint one;
        one = 64'sd16384 * 64'sd16384;
        m[0] = rnd_l(one - 2 * (y * y + z * z), 14);
        m[1] = rnd_l(2 * (x * y - w * z), 14);
        m[2] = rnd_l(2 * (x * z + w * y), 14);
        m[3] = rnd_l(2 * (x * y + w * z), 14);
        m[4] = rnd_l(one - 2 * (x * x + z * z), 14);
        m[5] = rnd_l(2 * (y * z - w * x), 14);
        m[6] = rnd_l(2 * (x * z - w * y), 14);
        m[7] = rnd_l(2 * (y * z + w * x), 14);
        m[8] = rnd_l(one - 2 * (x * x + y * y), 14);
    endtask

    task automatic predict_matrix(input t_req r, output t_res res);
        longint m [9];
        longint s, c, sa, ca, sb, cb, sc, cc;
        for (int j = 0; j < 9; j++) m[j] = 0;
        case (r.func)
            F_EULER: begin
                cordic_trig(angle_phase(r.angle_a), sa, ca);
                cordic_trig(angle_phase(r.angle_b), sb, cb);
                cordic_trig(angle_phase(r.angle_c), sc, cc);
                m[0] = rnd_l(ca * cc * 16384 - sa * cb * sc, 28);
                m[1] = rnd_l(-ca * sc * 16384 - sa * cb * cc, 28);
                m[2] = rnd_l(sa * sb, 14);
                m[3] = rnd_l(sa * cc * 16384 + ca * cb * sc, 28);
                m[4] = rnd_l(-sa * sc * 16384 + ca * cb * cc, 28);
                m[5] = rnd_l(-ca * sb, 14);
                m[6] = rnd_l(sb * sc, 14);
                m[7] = rnd_l(sb * cc, 14);
                m[8] = cb;
            end
            F_QUAT: quat_matrix(r.vec_w, r.vec_x, r.vec_y, r.vec_z, m);
            F_AXIS: begin
                cordic_trig(angle_phase(r.angle_a) >> 1, s, c);
                quat_matrix(c, rnd_l(s * r.vec_x, 14), rnd_l(s * r.vec_y, 14),
                            rnd_l(s * r.vec_z, 14), m);
            end
            F_ROT_X, F_ROT_Y, F_ROT_Z: begin
                cordic_trig(angle_phase(r.angle_a), s, c);
                if (r.func == F_ROT_X) begin
                    m[0] = 16384; m[4] = c; m[5] = -s; m[7] = s; m[8] = c;
                end else if (r.func == F_ROT_Y) begin
                    m[0] = c; m[2] = s; m[4] = 16384; m[6] = -s; m[8] = c;
                end else begin
                    m[0] = c; m[1] = -s; m[3] = s; m[4] = c; m[8] = 16384;
                end
            end
            default: begin
                m[0] = 16384; m[4] = 16384; m[8] = 16384;
            end
        endcase
        res.m00 = clamp_q14(m[0]); res.m01 = clamp_q14(m[1]); res.m02 = clamp_q14(m[2]);
        res.m10 = clamp_q14(m[3]); res.m11 = clamp_q14(m[4]); res.m12 = clamp_q14(m[5]);
        res.m20 = clamp_q14(m[6]); res.m21 = clamp_q14(m[7]); res.m22 = clamp_q14(m[8]);
    endtask

    // ---- driver ----
    // start is dropped only by the idle loop or the drain, so back-to-back words
    // never see two drives of start in one step
    task automatic send_request(input t_req r);
        t_res exp_m;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        predict_matrix(r, exp_m);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        matrix_q.push_back(exp_m);
        n_sent++;
        func_seen[r.func]++;
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        @(posedge i_clk);
        while (matrix_q.size() != 0) @(posedge i_clk);
    endtask

    // ---- checker ----
    task automatic report_field(string nm, logic signed [15:0] e, logic signed [15:0] a);
        if (e !== a) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch word %0d %s: exp %0d got %0d", n_matrices, nm, e, a);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && (o_valid || (start && !busy))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid) begin
            if (matrix_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected word from dut");
            end else begin
                t_res e;
                e = matrix_q.pop_front();
                report_field("m00", e.m00, o_res.m00);
                report_field("m01", e.m01, o_res.m01);
                report_field("m02", e.m02, o_res.m02);
                report_field("m10", e.m10, o_res.m10);
                report_field("m11", e.m11, o_res.m11);
                report_field("m12", e.m12, o_res.m12);
                report_field("m20", e.m20, o_res.m20);
                report_field("m21", e.m21, o_res.m21);
                report_field("m22", e.m22, o_res.m22);
            end
            n_matrices++;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("[rotation_matrix_generator_unit] ERROR");
            $finish;
        end
    end

    // ---- tests ----
    function automatic t_req random_request(logic [2:0] f);
        t_req r;
        r.func = f;
        r.angle_a = 16'($urandom);
        r.angle_b = 16'($urandom);
        r.angle_c = 16'($urandom);
        r.vec_w = 16'($urandom);
        r.vec_x = 16'($urandom);
        r.vec_y = 16'($urandom);
        r.vec_z = 16'($urandom);
        // unit-ish quaternions half the time, full-range noise otherwise
        if ($urandom_range(1, 0)) begin
            r.vec_w = 16'($signed($urandom_range(32768, 0)) - 16384);
            r.vec_x = 16'($signed($urandom_range(32768, 0)) - 16384);
            r.vec_y = 16'($signed($urandom_range(32768, 0)) - 16384);
            r.vec_z = 16'($signed($urandom_range(32768, 0)) - 16384);
        end
        if ($urandom_range(7, 0) == 0)
            r.angle_a = {3'($urandom_range(7, 0)), 13'h0};
        return r;
    endfunction

    task automatic test_directed();
        t_req r;
        logic [15:0] angles [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'hFFFF, 16'h2000};
        for (int f = 0; f < 8; f++) begin
            r = '0;
            r.func = 3'(f);
            r.angle_a = angles[f % 6];
            r.angle_b = angles[(f + 2) % 6];
            r.angle_c = angles[(f + 4) % 6];
            r.vec_w = 16'sh4000;
            r.vec_x = 16'sh2000;
            r.vec_y = -16'sh2000;
            r.vec_z = 16'sh1000;
            send_request(r);
        end
        // saturating quaternions and axes, wrap angles
        r = '{func: F_QUAT, angle_a: 0, angle_b: 0, angle_c: 0,
              vec_w: 16'sh7FFF, vec_x: 16'sh7FFF, vec_y: 16'sh7FFF, vec_z: 16'sh7FFF};
        send_request(r);
        r.vec_w = -16'sh8000; r.vec_x = -16'sh8000; r.vec_y = 16'sh7FFF; r.vec_z = -16'sh8000;
        send_request(r);
        r.vec_w = '0; r.vec_x = '0; r.vec_y = '0; r.vec_z = '0;
        send_request(r);
        r.func = F_AXIS; r.angle_a = 16'hFFFF;
        r.vec_x = -16'sh8000; r.vec_y = 16'sh7FFF; r.vec_z = -16'sh8000;
        send_request(r);
        r.angle_a = 16'h8000;
        send_request(r);
        r = '{func: F_EULER, angle_a: 16'hFFFF, angle_b: 16'hFFFF, angle_c: 16'hFFFF,
              vec_w: 16'sh7FFF, vec_x: -16'sh8000, vec_y: 0, vec_z: 0};
        send_request(r);
        r.angle_a = 16'h4000; r.angle_b = 16'hC000; r.angle_c = 16'h8000;
        send_request(r);
        drain_pending();
    endtask

    task automatic test_random(int n, int idle_pct);
        send_idle_pct = idle_pct;
        for (int i = 0; i < n; i++)
            send_request(random_request(3'($urandom_range(7, 0))));
        send_idle_pct = 0;
        drain_pending();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(N_RANDOM / 3, 21);
        test_random(N_RANDOM / 3, 77);
        test_random(N_RANDOM / 3, 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("sent %0d requests, checked %0d matrices", n_sent, n_matrices);
        $display("per func 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", func_seen[0],
                 func_seen[1], func_seen[2], func_seen[3], func_seen[4],
                 func_seen[5], func_seen[6], func_seen[7]);
        if (n_errors == 0 && matrix_q.size() == 0)
            $display("[rotation_matrix_generator_unit] OK");
        else
            $display("[rotation_matrix_generator_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rmg_pkg.sv
hw/rtl/rmg_front.sv
hw/rtl/rmg_queue.sv
hw/rtl/rmg_cordic.sv
hw/rtl/rmg_back.sv
hw/rtl/rotation_matrix_generator_unit.sv
tb/tb_rotation_matrix_generator_unit.sv
